/* hdl/psm_pkg.sv */
`default_nettype none
package psm_pkg;

  localparam int CAPACITY = 1024;
  localparam int VAL_W    = 32;
  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;

  // item traveling down the cell row
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic             hit;
    logic             placed;
    logic [VAL_W-1:0] value;
    logic [VAL_W:0]   comp;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] earlier;
  } tok_t;

endpackage
`default_nettype wire

/* hdl/psm_if.sv */
`default_nettype none
interface psm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [psm_pkg::VAL_W-1:0]     value;
  logic                                 first;
  logic                                 last;

  modport source (output valid, value, first, last, input ready);
  modport sink   (input valid, value, first, last, output ready);
endinterface

interface psm_out_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [psm_pkg::IDX_W-1:0]   earlier_index;
  logic [psm_pkg::IDX_W-1:0]   later_index;
  logic                        overflow;

  modport source (output valid, found, earlier_index, later_index, overflow, input ready);
  modport sink   (input valid, found, earlier_index, later_index, overflow, output ready);
endinterface
`default_nettype wire

/* hdl/psm_cell.sv */
`default_nettype none
module psm_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire psm_pkg::tok_t  tok_i,
  output psm_pkg::tok_t       tok_o
);

  logic                        valid_r, valid_nxt;
  logic [psm_pkg::VAL_W-1:0]   val_r, val_nxt;
  logic [psm_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  psm_pkg::tok_t               tok_r, tok_nxt;
  logic                        valid_eff;

  always_comb begin
    tok_nxt   = tok_i;
    valid_nxt = valid_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    valid_eff = valid_r;
    if (tok_i.vld) begin
      // a first item empties every cell as it passes
      valid_eff = tok_i.first ? 1'b0 : valid_r;
      valid_nxt = valid_eff;
      if (!tok_i.hit) begin
        if (valid_eff && ({val_r[psm_pkg::VAL_W-1], val_r} == tok_i.comp)) begin
          tok_nxt.hit     = 1'b1;
          tok_nxt.earlier = idx_r;
        end else if (!tok_i.placed) begin
          // a placed item still looks for its partner further down; an index
          // moved ahead of a hit is never read again since the set closes
          if (valid_eff && (val_r == tok_i.value)) begin
            idx_nxt        = tok_i.index;
            tok_nxt.placed = 1'b1;
          end else if (!valid_eff) begin
            // valid cells form a prefix, so the first empty one takes the value
            valid_nxt      = 1'b1;
            val_nxt        = tok_i.value;
            idx_nxt        = tok_i.index;
            tok_nxt.placed = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r.vld <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r <= val_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign tok_o = tok_r;

  a_hit_kept: assert property (@(posedge clk) disable iff (!rst_n)
    adv && tok_i.vld && tok_i.hit |=> tok_o.hit && tok_o.earlier == $past(tok_i.earlier))
    else $error("hit lost in cell");

  a_place_kept: assert property (@(posedge clk) disable iff (!rst_n)
    adv && tok_i.vld && tok_i.placed |=> tok_o.placed)
    else $error("placed item changed in cell");

endmodule
`default_nettype wire

/* hdl/psm_exit.sv */
`default_nettype none
module psm_exit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire psm_pkg::tok_t  tok_i,
  output logic                stall,
  psm_out_if.source           out_chan
);

  logic                        done_r, done_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        out_valid_r;
  logic                        found_r;
  logic [psm_pkg::IDX_W-1:0]   earlier_r, later_r;
  logic                        ovfo_r;
  logic                        done_eff, ovf_eff, live, tok_ovf, emit;

  always_comb begin
    done_eff = tok_i.first ? 1'b0 : done_r;
    ovf_eff  = tok_i.first ? 1'b0 : ovf_r;
    live     = tok_i.vld && !done_eff;
    tok_ovf  = !tok_i.hit && !tok_i.placed;
    emit     = live && (tok_i.hit || tok_i.last);
    done_nxt = done_r;
    ovf_nxt  = ovf_r;
    if (tok_i.vld) begin
      done_nxt = done_eff || emit;
      ovf_nxt  = ovf_eff || (live && tok_ovf);
    end
    stall = out_valid_r && !out_chan.ready && emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        done_r <= done_nxt;
        ovf_r  <= ovf_nxt;
      end
      if (adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit) begin
      found_r   <= tok_i.hit;
      earlier_r <= tok_i.hit ? tok_i.earlier : '0;
      later_r   <= tok_i.hit ? tok_i.index : '0;
      ovfo_r    <= tok_i.hit ? ovf_eff : (ovf_eff || tok_ovf);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.found         = found_r;
  assign out_chan.earlier_index = earlier_r;
  assign out_chan.later_index   = later_r;
  assign out_chan.overflow      = ovfo_r;

  a_hit_emits: assert property (@(posedge clk) disable iff (!rst_n)
    adv && emit && tok_i.hit |=> out_chan.valid && out_chan.found)
    else $error("hit item gave no found result");

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.found |-> out_chan.earlier_index == '0 &&
      out_chan.later_index == '0)
    else $error("not-found result carries indices");

  a_drop_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    adv && tok_i.vld && !tok_i.first && done_r && !out_valid_r |=> !out_chan.valid)
    else $error("item after a result was not dropped");

endmodule
`default_nettype wire

/* hdl/pair_sum_matcher_core.sv */
// Path: an accepted item passes the entry register, then the CAPACITY cells
//   (one register in each), then the output register.
// Throughput: one item per cycle; the whole cell row stalls only while a result
//   meets a held, untaken output register.
// Reset (synchronous, rst_n low): all cell valid bits, set tracking and the output
//   are cleared; target_r returns to 0.
`default_nettype none
module pair_sum_matcher_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [psm_pkg::VAL_W-1:0]    cfg_wdata,
  psm_in_if.sink                            in_chan,
  psm_out_if.source                         out_chan
);

  psm_pkg::tok_t               chain [0:psm_pkg::CAPACITY];
  psm_pkg::tok_t               tok0_r, tok0_nxt;
  logic [psm_pkg::VAL_W-1:0]   target_r;
  logic [psm_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, cnt_eff;
  logic                        done_r, done_nxt, done_eff;
  logic                        adv, stall;

  assign adv           = !stall;
  assign in_chan.ready = adv;

  always_comb begin
    cnt_eff  = in_chan.first ? '0 : cnt_r;
    done_eff = in_chan.first ? 1'b0 : done_r;
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    tok0_nxt         = tok0_r;
    tok0_nxt.vld     = 1'b0;
    if (in_chan.valid) begin
      cnt_nxt  = cnt_eff;
      done_nxt = done_eff;
      if (!done_eff) begin
        tok0_nxt.vld     = 1'b1;
        tok0_nxt.first   = in_chan.first;
        tok0_nxt.last    = in_chan.last;
        tok0_nxt.hit     = 1'b0;
        tok0_nxt.placed  = 1'b0;
        tok0_nxt.value   = in_chan.value;
        tok0_nxt.comp    = {target_r[psm_pkg::VAL_W-1], target_r} -
                           {in_chan.value[psm_pkg::VAL_W-1], in_chan.value};
        tok0_nxt.index   = cnt_eff[psm_pkg::IDX_W-1:0];
        tok0_nxt.earlier = '0;
        cnt_nxt          = cnt_eff + 1'b1;
        done_nxt         = in_chan.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= '0;
      cnt_r      <= '0;
      done_r     <= 1'b0;
      tok0_r.vld <= 1'b0;
    end else begin
      if (cfg_we) begin
        target_r <= cfg_wdata;
      end
      if (adv) begin
        cnt_r  <= cnt_nxt;
        done_r <= done_nxt;
        tok0_r <= tok0_nxt;
      end
    end
  end

  assign chain[0] = tok0_r;

  for (genvar k = 0; k < psm_pkg::CAPACITY; k++) begin : g_cell
    psm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .tok_i (chain[k]),
      .tok_o (chain[k+1])
    );
  end

  psm_exit u_exit (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .tok_i    (chain[psm_pkg::CAPACITY]),
    .stall    (stall),
    .out_chan (out_chan)
  );

  a_entry_drop: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_chan.valid && !in_chan.first && done_r |=> !tok0_r.vld)
    else $error("item after last entered the cell row");

endmodule
`default_nettype wire
